### hdl/thi_pkg.sv
`default_nettype none
package thi_pkg;
  localparam int RECORDS_DEF = 16;
  localparam int COMP_W = 20;
  localparam int NCOMP = 9;
  localparam int TIME_W = 32;
  localparam int PER_W = 10;
  localparam int QUO_W = COMP_W + 1;
  localparam int PROD_W = TIME_W + QUO_W;
  localparam logic [PER_W-1:0] PERIOD_DEF = PER_W'(50);

  localparam logic [1:0] FUNC_STORE = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_FILL  = 2'd2;

  // box components: origin xyz, low xyz, high xyz
  typedef logic [NCOMP-1:0][COMP_W-1:0] box_t;

  typedef struct packed {
    logic signed [TIME_W-1:0] stamp;
    box_t                     box;
  } rec_t;
endpackage
`default_nettype wire

### hdl/thi_if.sv
`default_nettype none
interface thi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] now_time;
  logic signed [31:0] query_time;
  logic signed [19:0] origin_x;
  logic signed [19:0] origin_y;
  logic signed [19:0] origin_z;
  logic signed [19:0] low_x;
  logic signed [19:0] low_y;
  logic signed [19:0] low_z;
  logic signed [19:0] high_x;
  logic signed [19:0] high_y;
  logic signed [19:0] high_z;
  modport source (output valid, func, now_time, query_time, origin_x, origin_y, origin_z,
                  low_x, low_y, low_z, high_x, high_y, high_z, input ready);
  modport sink (input valid, func, now_time, query_time, origin_x, origin_y, origin_z,
                low_x, low_y, low_z, high_x, high_y, high_z, output ready);
endinterface

interface thi_out_if;
  logic               valid;
  logic               ready;
  logic               adjusted;
  logic signed [19:0] out_origin_x;
  logic signed [19:0] out_origin_y;
  logic signed [19:0] out_origin_z;
  logic signed [19:0] out_low_x;
  logic signed [19:0] out_low_y;
  logic signed [19:0] out_low_z;
  logic signed [19:0] out_high_x;
  logic signed [19:0] out_high_y;
  logic signed [19:0] out_high_z;
  modport source (output valid, adjusted, out_origin_x, out_origin_y, out_origin_z,
                  out_low_x, out_low_y, out_low_z, out_high_x, out_high_y, out_high_z,
                  input ready);
  modport sink (input valid, adjusted, out_origin_x, out_origin_y, out_origin_z,
                out_low_x, out_low_y, out_low_z, out_high_x, out_high_y, out_high_z,
                output ready);
endinterface
`default_nettype wire

### hdl/timestamped_history_interpolator_top.sv
// channel | dir | handshake      | word
// req     | in  | valid/ready    | func, times, box
// rsp     | out | valid/ready    | adjusted, box
// cfg     | in  | cfg_wr_en only | fill_period
//
// Store writes its record on accept. Fill writes RECORDS records, one record written per cycle.
// Query: S_RD then S_CMP for each record visited in the backward search (single read
// port), then per component a multiply, 21 divide steps and an add,
// for 9 components.
// req.ready is high only while the sequencer is idle. A finished word sits
// in the output register until taken; rst clears control state and the
// per-record valid bits (an unwritten record reads as all zero).
`default_nettype none
module timestamped_history_interpolator_top #(
  parameter int RECORDS = thi_pkg::RECORDS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [thi_pkg::PER_W-1:0]    cfg_wr_data,
  thi_in_if.sink                            req,
  thi_out_if.source                         rsp
);
  import thi_pkg::*;

  localparam int SW = $clog2(RECORDS);
  localparam logic [SW-1:0] LAST = SW'(RECORDS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_ADD  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]               state;
  logic [PER_W-1:0]         fill_period;
  logic [SW-1:0]            newest;
  logic [SW-1:0]            islot;
  logic [SW-1:0]            cnt;
  logic [TIME_W-1:0]        ftime;
  logic signed [TIME_W-1:0] qt;
  logic                     first;
  rec_t                     jrec;
  box_t                     abox;
  box_t                     ibox;
  logic [TIME_W-1:0]        num;
  logic [TIME_W-1:0]        den;
  logic [PROD_W-1:0]        acc;
  logic                     neg;
  logic [4:0]               step;
  logic [3:0]               k;
  logic                     res_adj;
  box_t                     res_box;
  logic                     ovalid;
  logic                     o_adj;
  box_t                     o_box;

  rec_t                     mem [RECORDS];
  logic [RECORDS-1:0]       vld;
  rec_t                     rd;
  logic                     rd_v;
  rec_t                     rdv;

  logic                     acc_in;
  logic                     we;
  logic [SW-1:0]            waddr;
  rec_t                     wdata;
  box_t                     in_box;
  logic [SW-1:0]            st_slot;
  logic [PER_W-1:0]         per;
  logic [SW-1:0]            iprev;
  logic [COMP_W:0]          dif;
  logic [QUO_W-1:0]         mag;
  logic [TIME_W:0]          r2;
  logic                     ge;
  logic [TIME_W:0]          nrem;
  logic [QUO_W-1:0]         sq;
  logic [COMP_W:0]          sum;
  logic                     out_free;

  assign req.ready = (state == S_IDLE);
  assign acc_in    = req.valid && req.ready;
  assign in_box    = {req.high_z, req.high_y, req.high_x, req.low_z, req.low_y, req.low_x,
                      req.origin_z, req.origin_y, req.origin_x};
  assign st_slot   = (newest == LAST) ? '0 : newest + 1'b1;
  assign per       = (fill_period == '0) ? PERIOD_DEF : fill_period;
  assign iprev     = (islot == '0) ? LAST : islot - 1'b1;
  assign rdv       = rd_v ? rd : '0;
  assign out_free  = !ovalid || rsp.ready;

  // memory write port: store on accept, fill sweep
  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = '{stamp: ftime, box: ibox};
    if (acc_in && req.func == FUNC_STORE) begin
      we    = 1'b1;
      waddr = st_slot;
      wdata = '{stamp: req.now_time, box: in_box};
    end else if (state == S_FILL) begin
      we = 1'b1;
    end
  end

  // record memory with registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd   <= mem[islot];
    rd_v <= vld[islot];
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (we) vld[waddr] <= 1'b1;
  end

  // shared arithmetic: difference magnitude, divide step, final add
  always_comb begin
    dif  = {jrec.box[k][COMP_W-1], jrec.box[k]} - {abox[k][COMP_W-1], abox[k]};
    mag  = dif[COMP_W] ? QUO_W'(-dif) : QUO_W'(dif);
    r2   = {acc[PROD_W-1:QUO_W], acc[QUO_W-1]};
    ge   = (r2 >= {1'b0, den});
    nrem = ge ? r2 - {1'b0, den} : r2;
    sq   = neg ? -acc[QUO_W-1:0] : acc[QUO_W-1:0];
    sum  = {abox[k][COMP_W-1], abox[k]} + sq;
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) fill_period <= PERIOD_DEF;
    else if (cfg_wr_en) fill_period <= cfg_wr_data;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      newest <= '0;
      ovalid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) ovalid <= 1'b1;
      else if (rsp.ready) ovalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (acc_in) begin
            res_adj <= 1'b0;
            res_box <= '0;
            ibox    <= in_box;
            ftime   <= req.now_time;
            qt      <= (req.query_time > req.now_time) ? req.now_time : req.query_time;
            islot   <= newest;
            first   <= 1'b1;
            cnt     <= LAST;
            case (req.func)
              FUNC_STORE: begin
                newest <= st_slot;
                state  <= S_DONE;
              end
              FUNC_QUERY: state <= S_RD;
              FUNC_FILL: begin
                newest <= LAST;
                state  <= S_FILL;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_FILL: begin
          ftime <= ftime - TIME_W'(per);
          cnt   <= cnt - 1'b1;
          if (cnt == '0) state <= S_DONE;
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (rdv.stamp <= qt) begin
            if (first) begin
              state <= S_DONE;
            end else begin
              abox  <= rdv.box;
              num   <= qt - rdv.stamp;
              den   <= jrec.stamp - rdv.stamp;
              k     <= '0;
              state <= S_MUL;
            end
          end else begin
            jrec  <= rdv;
            first <= 1'b0;
            if (iprev == newest) begin
              res_adj <= 1'b1;
              res_box <= rdv.box;
              state   <= S_DONE;
            end else begin
              islot <= iprev;
              state <= S_RD;
            end
          end
        end
        S_MUL: begin
          acc   <= PROD_W'(mag) * PROD_W'(num);
          neg   <= dif[COMP_W];
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          acc  <= {nrem[TIME_W-1:0], acc[QUO_W-2:0], ge};
          step <= step + 1'b1;
          if (step == 5'(QUO_W - 1)) state <= S_ADD;
        end
        S_ADD: begin
          res_box[k] <= sum[COMP_W-1:0];
          if (k == 4'(NCOMP - 1)) begin
            res_adj <= 1'b1;
            state   <= S_DONE;
          end else begin
            k     <= k + 1'b1;
            state <= S_MUL;
          end
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      o_adj <= res_adj;
      o_box <= res_box;
    end
  end

  assign rsp.valid        = ovalid;
  assign rsp.adjusted     = o_adj;
  assign rsp.out_origin_x = o_box[0];
  assign rsp.out_origin_y = o_box[1];
  assign rsp.out_origin_z = o_box[2];
  assign rsp.out_low_x    = o_box[3];
  assign rsp.out_low_y    = o_box[4];
  assign rsp.out_low_z    = o_box[5];
  assign rsp.out_high_x   = o_box[6];
  assign rsp.out_high_y   = o_box[7];
  assign rsp.out_high_z   = o_box[8];
endmodule
`default_nettype wire

### hdl/thi_check.sv
`default_nettype none
module thi_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        adj,
  input wire logic [19:0] ox,
  input wire logic [19:0] hz
);
  // a word waits until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("rsp dropped");

  // idle after reset, nothing pending
  a_rst: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid) else $error("not idle after reset");

  // the sequencer is busy the cycle after taking a word
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");

  // unadjusted words carry an empty box
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !adj |-> ox == '0 && hz == '0) else $error("box not zero");
endmodule

bind timestamped_history_interpolator_top thi_check u_thi_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .adj       (rsp.adjusted),
  .ox        (rsp.out_origin_x),
  .hz        (rsp.out_high_z)
);
`default_nettype wire

### dv/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import thi_pkg::*;

  localparam int NREC = RECORDS_DEF;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [PER_W-1:0] cfg_wr_data;

  thi_in_if req ();
  thi_out_if rsp ();

  timestamped_history_interpolator_top #(.RECORDS(NREC)) uut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .req(req.sink), .rsp(rsp.source)
  );

  typedef struct {
    logic [1:0]         func;
    logic signed [31:0] now_t;
    logic signed [31:0] qry_t;
    logic signed [19:0] box [9];
  } req_word_t;

  typedef struct {
    logic               adjusted;
    logic signed [19:0] box [9];
  } rsp_word_t;

  // predictor state
  logic [PER_W-1:0]   mdl_period;
  int                 mdl_newest;
  logic signed [31:0] mdl_stamp [NREC];
  logic signed [19:0] mdl_box [NREC][9];

  rsp_word_t expected_q [$];
  int errors;
  int n_rsp;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch at rsp %0d: %s", n_rsp, msg);
    errors++;
  endtask

  // box history: apply one request word and return the predicted response
  function automatic rsp_word_t history_step(input req_word_t w);
    rsp_word_t r;
    logic [31:0] t;
    logic [31:0] per;
    logic signed [31:0] q;
    int i, j;
    longint num, den, d;
    r.adjusted = 1'b0;
    for (int k = 0; k < 9; k++) r.box[k] = '0;
    case (w.func)
      FUNC_STORE: begin
        mdl_newest = (mdl_newest + 1) % NREC;
        mdl_stamp[mdl_newest] = w.now_t;
        for (int k = 0; k < 9; k++) mdl_box[mdl_newest][k] = w.box[k];
      end
      FUNC_FILL: begin
        per = (mdl_period == 0) ? 32'd50 : 32'(mdl_period);
        t = w.now_t;
        mdl_newest = NREC - 1;
        for (int s = NREC - 1; s >= 0; s--) begin
          mdl_stamp[s] = t;
          for (int k = 0; k < 9; k++) mdl_box[s][k] = w.box[k];
          t = t - per;
        end
      end
      FUNC_QUERY: begin
        q = (w.qry_t > w.now_t) ? w.now_t : w.qry_t;
        i = mdl_newest;
        j = mdl_newest;
        do begin
          if (mdl_stamp[i] <= q) break;
          j = i;
          i = (i == 0) ? NREC - 1 : i - 1;
        end while (i != mdl_newest);
        if (i != j) begin
          r.adjusted = 1'b1;
          if (i != mdl_newest) begin
            num = longint'(q) - longint'(mdl_stamp[i]);
            den = longint'(mdl_stamp[j]) - longint'(mdl_stamp[i]);
            if (den <= 0) den = 1;
            for (int k = 0; k < 9; k++) begin
              d = longint'(mdl_box[j][k]) - longint'(mdl_box[i][k]);
              r.box[k] = 20'(longint'(mdl_box[i][k]) + (d * num) / den);
            end
          end else begin
            for (int k = 0; k < 9; k++) r.box[k] = mdl_box[j][k];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic req_word_t make_word(input logic [1:0] f, input logic signed [31:0] nt,
                                          input logic signed [31:0] qt,
                                          input logic signed [19:0] v);
    req_word_t w;
    w.func = f;
    w.now_t = nt;
    w.qry_t = qt;
    for (int k = 0; k < 9; k++) w.box[k] = v + 20'(k);
    return w;
  endfunction

  function automatic req_word_t rand_word(input logic signed [31:0] now_base);
    req_word_t w;
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) w.func = FUNC_STORE;
    else if (sel < 85) w.func = FUNC_QUERY;
    else if (sel < 95) w.func = FUNC_FILL;
    else w.func = 2'd3;
    if ($urandom_range(9) == 0) w.now_t = $urandom;
    else w.now_t = now_base;
    if ($urandom_range(9) == 0) w.qry_t = $urandom;
    else w.qry_t = w.now_t - 32'($urandom_range(900)) + 32'sd20;
    for (int k = 0; k < 9; k++) begin
      if ($urandom_range(3) == 0) w.box[k] = 20'($urandom);
      else w.box[k] = 20'($urandom_range(4000)) - 20'sd2000;
    end
    return w;
  endfunction

  task automatic idle_gap();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(2);
    repeat (n) @(posedge clk);
  endtask

  // hand one word to the block; the predicted response is queued on accept
  task automatic send_word(input req_word_t w, input bit chk, input rsp_word_t fixed);
    rsp_word_t r;
    req.valid <= 1'b1;
    req.func <= w.func;
    req.now_time <= w.now_t;
    req.query_time <= w.qry_t;
    req.origin_x <= w.box[0]; req.origin_y <= w.box[1]; req.origin_z <= w.box[2];
    req.low_x <= w.box[3];    req.low_y <= w.box[4];    req.low_z <= w.box[5];
    req.high_x <= w.box[6];   req.high_y <= w.box[7];   req.high_z <= w.box[8];
    do @(posedge clk); while (!req.ready);
    r = history_step(w);
    if (chk && (r.adjusted !== fixed.adjusted || r.box != fixed.box))
      report("table row disagrees with predictor");
    expected_q.push_back(r);
    req.valid <= 1'b0;
    // the block is busy for at least this cycle after an accept
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_period(input logic [PER_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mdl_period = v;
  endtask

  // response side: random backpressure, compare against oldest prediction
  initial begin
    rsp_word_t e;
    logic signed [19:0] got [9];
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.out_origin_x, rsp.out_origin_y, rsp.out_origin_z,
                rsp.out_low_x, rsp.out_low_y, rsp.out_low_z,
                rsp.out_high_x, rsp.out_high_y, rsp.out_high_z};
        if (expected_q.size() == 0) begin
          report("unexpected word");
        end else begin
          e = expected_q.pop_front();
          if (rsp.adjusted !== e.adjusted)
            report($sformatf("adjusted %b exp %b", rsp.adjusted, e.adjusted));
          for (int k = 0; k < 9; k++)
            if (got[k] !== e.box[k])
              report($sformatf("comp %0d got %0d exp %0d", k, got[k], e.box[k]));
        end
        n_rsp++;
      end
      if ($urandom_range(19) == 0) rsp.ready <= 1'b0;
      else if ($urandom_range(3) == 0) rsp.ready <= ($urandom_range(2) != 0);
      else rsp.ready <= 1'b1;
    end
  end

  typedef struct {
    req_word_t w;
    bit        chk;
    rsp_word_t r;
  } row_t;

  initial begin
    row_t rows [$];
    row_t row;
    rsp_word_t zero_r, old_r;
    logic signed [31:0] tnow;
    logic [PER_W-1:0] periods [4];
    errors = 0;
    n_rsp = 0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req.valid = 1'b0;
    req.func = FUNC_STORE;
    req.now_time = '0; req.query_time = '0;
    req.origin_x = '0; req.origin_y = '0; req.origin_z = '0;
    req.low_x = '0; req.low_y = '0; req.low_z = '0;
    req.high_x = '0; req.high_y = '0; req.high_z = '0;
    mdl_period = PERIOD_DEF;
    mdl_newest = 0;
    for (int s = 0; s < NREC; s++) begin
      mdl_stamp[s] = '0;
      for (int k = 0; k < 9; k++) mdl_box[s][k] = '0;
    end
    zero_r.adjusted = 1'b0;
    for (int k = 0; k < 9; k++) zero_r.box[k] = '0;
    old_r.adjusted = 1'b1;
    for (int k = 0; k < 9; k++) old_r.box[k] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: after reset, extremes, future query, unknown func, wraps
    rows.push_back('{make_word(FUNC_QUERY, 32'sd0, 32'sd5, 20'sd0), 1, zero_r});
    rows.push_back('{make_word(FUNC_QUERY, 32'sd10, -32'sd1, 20'sd0), 1, old_r});
    rows.push_back('{make_word(2'd3, 32'sd7, 32'sd7, 20'sd99), 1, zero_r});
    rows.push_back('{make_word(FUNC_STORE, 32'sd100, 0, 20'sh80000), 1, zero_r});
    rows.push_back('{make_word(FUNC_STORE, 32'sd200, 0, 20'sh7FFF0), 1, zero_r});
    rows.push_back('{make_word(FUNC_QUERY, 32'sd300, 32'sd150, 20'sd0), 0, zero_r});
    rows.push_back('{make_word(FUNC_QUERY, 32'sd300, 32'sd500, 20'sd0), 1, zero_r});
    rows.push_back('{make_word(FUNC_FILL, 32'sh80000010, 0, 20'sh7FFF6), 1, zero_r});
    rows.push_back('{make_word(FUNC_QUERY, 32'sh7FFFFFFF, 32'sh7FFFFF00, 20'sd0), 0, zero_r});
    rows.push_back('{make_word(FUNC_QUERY, 32'sh80000010, 32'sh80000000, 20'sd0), 0, zero_r});
    rows.push_back('{make_word(FUNC_FILL, 32'sd1000, 0, -20'sd500), 1, zero_r});
    rows.push_back('{make_word(FUNC_STORE, 32'sd1100, 0, 20'sd500), 1, zero_r});
    rows.push_back('{make_word(FUNC_QUERY, 32'sd1100, 32'sd1033, 20'sd0), 0, zero_r});
    rows.push_back('{make_word(FUNC_QUERY, 32'sd1100, 32'sd925, 20'sd0), 0, zero_r});
    rows.push_back('{make_word(FUNC_QUERY, 32'sh80000000, 32'sh80000000, 20'sd0), 0, zero_r});
    foreach (rows[n]) begin
      row = rows[n];
      send_word(row.w, row.chk, row.r);
      idle_gap();
    end
    wait_drain();

    // random phases across period settings, zero and extremes included
    periods = '{10'd1, 10'd0, 10'd1023, 10'd1000};
    tnow = 32'sd5000;
    for (int p = 0; p < 4; p++) begin
      write_period(periods[p]);
      for (int n = 0; n < 200; n++) begin
        row.w = rand_word(tnow);
        send_word(row.w, 0, zero_r);
        tnow = tnow + 32'($urandom_range(80));
        if (n == 100) wait_drain();
        else if ($urandom_range(4) != 0) idle_gap();
      end
      wait_drain();
    end

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
